### sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants of the alarm snooze controller
// Holds the field codes, the register indexes, the timing constants and the
// structs that travel between the configuration, engine and top level.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PERIOD_W   = 23;  // 99 minutes in ms fits in 23 bits
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0]       MS_PER_MINUTE   = 16'd60000;
  localparam logic [TIME_W-1:0] GUARD_MS        = 32'd62000;
  localparam logic [TIME_W-1:0] RING_TIMEOUT_MS = 32'd600000;

  // Item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SNOOZE = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_MODE   = 2'd3;

  // Alarm modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;
  localparam logic [1:0] MODE_SKIP   = 2'd3;

  // Lamp commands
  localparam logic [1:0] LAMP_NONE = 2'd0;
  localparam logic [1:0] LAMP_ON   = 2'd1;
  localparam logic [1:0] LAMP_OFF  = 2'd2;

  // Buzzer commands
  localparam logic [1:0] BUZZ_NONE    = 2'd0;
  localparam logic [1:0] BUZZ_OFF     = 2'd1;
  localparam logic [1:0] BUZZ_REGULAR = 2'd2;
  localparam logic [1:0] BUZZ_LAST    = 2'd3;

  // Ambient light commands
  localparam logic [1:0] AMB_NONE     = 2'd0;
  localparam logic [1:0] AMB_FADE_IN  = 2'd1;
  localparam logic [1:0] AMB_FADE_OUT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_MASK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SNOOZE_MINUTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SNOOZE_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_FLAGS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_LEVEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INHIBIT        = 3'd7;

  typedef struct packed {
    logic [4:0]          alarm_hour;
    logic [5:0]          alarm_minute;
    logic [6:0]          day_mask;
    logic [3:0]          snooze_limit;
    logic [1:0]          signal_flags;
    logic [7:0]          ambient_level;
    logic                inhibit;
    logic [PERIOD_W-1:0] snooze_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] now_ms;
    logic [2:0]        weekday;
    logic [4:0]        hour_now;
    logic [5:0]        minute_now;
    logic [1:0]        mode_value;
  } item_t;

  typedef struct packed {
    logic [1:0] lamp_cmd;
    logic [1:0] buzzer_cmd;
    logic [1:0] ambient_cmd;
    logic [7:0] ambient_target;
    logic       activated;
    logic       stopped;
    logic       persist_request;
    logic [1:0] mode_now;
    logic       is_active;
    logic       is_snoozing;
    logic [3:0] snoozes_left;
    logic       write_ok;
  } result_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              active;
    logic              snoozing;
    logic [3:0]        snooze_remaining;
    logic [TIME_W-1:0] snooze_start_time;
    logic [TIME_W-1:0] activation_time;
    logic              activation_seen;
  } state_t;

endpackage

### sv/asc_ifs.sv
// ----------------------------------------------------------------------------
// asc_ifs: stream channels of the alarm snooze controller
// One channel for input beats and one for result beats, valid/ready each.
// ----------------------------------------------------------------------------
interface asc_item_if;
  logic          valid;
  logic          ready;
  asc_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asc_result_if;
  logic            valid;
  logic            ready;
  asc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/asc_cfg.sv
// ----------------------------------------------------------------------------
// asc_cfg: configuration registers
// Write one register per enabled cycle and keep the snooze period in ms.
// ----------------------------------------------------------------------------
module asc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wen,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]  wdata,
  output asc_pkg::cfg_t                   cfg
);

  asc_pkg::cfg_t                regs;
  logic [asc_pkg::PERIOD_W-1:0] period_next;

  // One narrow product: 7-bit minutes times the 16-bit ms-per-minute constant,
  // taken from the write data so the period lands with the write itself
  assign period_next = asc_pkg::PERIOD_W'(wdata[6:0]) *
                       asc_pkg::PERIOD_W'(asc_pkg::MS_PER_MINUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      if (wen) begin
        unique case (index)
          asc_pkg::REG_ALARM_HOUR:     regs.alarm_hour    <= wdata[4:0];
          asc_pkg::REG_ALARM_MINUTE:   regs.alarm_minute  <= wdata[5:0];
          asc_pkg::REG_DAY_MASK:       regs.day_mask      <= wdata[6:0];
          asc_pkg::REG_SNOOZE_MINUTES: regs.snooze_period <= period_next;
          asc_pkg::REG_SNOOZE_LIMIT:   regs.snooze_limit  <= wdata[3:0];
          asc_pkg::REG_SIGNAL_FLAGS:   regs.signal_flags  <= wdata[1:0];
          asc_pkg::REG_AMBIENT_LEVEL:  regs.ambient_level <= wdata[7:0];
          asc_pkg::REG_INHIBIT:        regs.inhibit       <= wdata[0];
        endcase
      end
    end
  end

  assign cfg = regs;

endmodule

### sv/asc_engine.sv
// ----------------------------------------------------------------------------
// asc_engine: alarm state and single-pass item update
// Hold the alarm state and work out one result from one registered item.
// ----------------------------------------------------------------------------
module asc_engine (
  input  logic             clk,
  input  logic             rst,
  input  asc_pkg::cfg_t    cfg,
  input  asc_pkg::item_t   item,
  input  logic             en,
  output asc_pkg::result_t res
);

  asc_pkg::state_t st;
  asc_pkg::state_t st_next;

  logic [asc_pkg::TIME_W-1:0] since_act;
  logic [asc_pkg::TIME_W-1:0] since_snooze;
  logic [7:0]                 mask8;
  logic                       day_ok;
  logic                       guard_hold;
  logic                       time_match;

  assign since_act    = item.now_ms - st.activation_time;
  assign since_snooze = item.now_ms - st.snooze_start_time;
  // Weekday seven lands on the zero pad bit and never matches
  assign mask8        = {1'b0, cfg.day_mask};
  assign day_ok       = mask8[item.weekday];
  assign guard_hold   = st.activation_seen && (since_act < asc_pkg::GUARD_MS);
  assign time_match   = (item.hour_now == cfg.alarm_hour) &&
                        (item.minute_now == cfg.alarm_minute);

  always_comb begin
    st_next = st;
    res     = '0;

    unique case (item.kind)
      asc_pkg::KIND_TICK: begin
        if (st.active) begin
          if (st.snoozing) begin
            if (since_snooze >= asc_pkg::TIME_W'(cfg.snooze_period)) begin
              st_next.snoozing        = 1'b0;
              st_next.activation_time = item.now_ms;
              if (cfg.signal_flags[0]) res.lamp_cmd = asc_pkg::LAMP_ON;
              if (cfg.signal_flags[1]) begin
                res.buzzer_cmd = (st.snooze_remaining == '0) ? asc_pkg::BUZZ_LAST
                                                             : asc_pkg::BUZZ_REGULAR;
              end
            end
          end else if (since_act >= asc_pkg::RING_TIMEOUT_MS) begin
            st_next.active           = 1'b0;
            st_next.snoozing         = 1'b0;
            st_next.snooze_remaining = '0;
            res.ambient_cmd          = asc_pkg::AMB_FADE_OUT;
            res.stopped              = 1'b1;
            if (cfg.signal_flags[0]) res.lamp_cmd   = asc_pkg::LAMP_OFF;
            if (cfg.signal_flags[1]) res.buzzer_cmd = asc_pkg::BUZZ_OFF;
          end
        end else if (!guard_hold && day_ok && time_match &&
                     (st.mode != asc_pkg::MODE_OFF)) begin
          st_next.activation_time = item.now_ms;
          st_next.activation_seen = 1'b1;
          if (st.mode == asc_pkg::MODE_SINGLE) begin
            st_next.mode        = asc_pkg::MODE_OFF;
            res.persist_request = 1'b1;
          end
          if (st.mode == asc_pkg::MODE_SKIP) begin
            // Skip one occurrence: switch to repeat and stay silent
            st_next.mode        = asc_pkg::MODE_REPEAT;
            res.persist_request = 1'b1;
          end else if (!cfg.inhibit) begin
            st_next.snooze_remaining = cfg.snooze_limit;
            st_next.snoozing         = 1'b0;
            st_next.active           = 1'b1;
            res.ambient_cmd          = asc_pkg::AMB_FADE_IN;
            res.ambient_target       = cfg.ambient_level;
            res.activated            = 1'b1;
            if (cfg.signal_flags[0]) res.lamp_cmd = asc_pkg::LAMP_ON;
            if (cfg.signal_flags[1]) begin
              res.buzzer_cmd = (cfg.snooze_limit == '0) ? asc_pkg::BUZZ_LAST
                                                        : asc_pkg::BUZZ_REGULAR;
            end
          end
        end
      end
      asc_pkg::KIND_SNOOZE: begin
        if (st.active && !st.snoozing && (st.snooze_remaining != '0)) begin
          st_next.snoozing          = 1'b1;
          st_next.snooze_remaining  = st.snooze_remaining - 4'd1;
          st_next.snooze_start_time = item.now_ms;
          if (cfg.signal_flags[0]) res.lamp_cmd   = asc_pkg::LAMP_OFF;
          if (cfg.signal_flags[1]) res.buzzer_cmd = asc_pkg::BUZZ_OFF;
        end
      end
      asc_pkg::KIND_STOP: begin
        if (st.active) begin
          st_next.active           = 1'b0;
          st_next.snoozing         = 1'b0;
          st_next.snooze_remaining = '0;
          res.ambient_cmd          = asc_pkg::AMB_FADE_OUT;
          res.stopped              = 1'b1;
          if (cfg.signal_flags[0]) res.lamp_cmd   = asc_pkg::LAMP_OFF;
          if (cfg.signal_flags[1]) res.buzzer_cmd = asc_pkg::BUZZ_OFF;
        end
      end
      asc_pkg::KIND_MODE: begin
        st_next.mode = item.mode_value;
        res.write_ok = 1'b1;
      end
    endcase

    res.mode_now     = st_next.mode;
    res.is_active    = st_next.active;
    res.is_snoozing  = st_next.active && st_next.snoozing;
    res.snoozes_left = st_next.active ? st_next.snooze_remaining : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (en) begin
      st <= st_next;
    end
  end

endmodule

### sv/alarm_snooze_controller.sv
// ----------------------------------------------------------------------------
// alarm_snooze_controller: alarm with snooze, stop and ring timeout
// Input register, one pass of update logic, result register.
// ----------------------------------------------------------------------------
// Path: an accepted beat waits in the input register, and the engine result
//   is loaded into the result register when that beat advances.
// Throughput: one beat per cycle; the input register, the engine state and
//   the result register all advance together when the result slot is free.
// Reset (rst, synchronous, active high) clears all configuration registers,
//   the alarm state (mode off, not ringing, guard not armed) and both valids.
module alarm_snooze_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_data,
  asc_item_if.sink                        item,
  asc_result_if.source                    result
);

  asc_pkg::cfg_t    cfg;
  asc_pkg::item_t   in_data;
  asc_pkg::result_t eng_res;
  asc_pkg::result_t out_data;
  logic             in_valid;
  logic             out_valid;
  logic             advance;

  // Move the held beat through the engine whenever the result slot is empty
  // or is being drained in this same cycle.
  assign advance    = in_valid && (!out_valid || result.ready);
  // Take a new beat when the input register is empty or is moving on.
  assign item.ready = !in_valid || advance;

  asc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wen   (cfg_wen),
    .index (cfg_index),
    .wdata (cfg_data),
    .cfg   (cfg)
  );

  // State updates only on advance, so each beat is applied exactly once.
  asc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_data),
    .en   (advance),
    .res  (eng_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data <= '0;
    end else if (item.valid && item.ready) begin
      in_data <= item.data;
    end
  end

  // Result register: load on advance, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= eng_res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // A start of ringing always leaves the alarm active
  a_activated_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.activated) |-> out_data.is_active)
    else $error("activated beat without active alarm");

  // A stop always leaves the alarm idle
  a_stopped_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stopped) |-> !out_data.is_active)
    else $error("stopped beat with alarm still active");

  // Snooze status and snooze count only show while active
  a_snooze_needs_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.is_snoozing || (out_data.snoozes_left != 4'd0)))
      |-> out_data.is_active)
    else $error("snooze status shown while alarm is not active");

  // A beat moved into the result register must show up as a valid result
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat lost before the result register");

endmodule

### tb/sv/tb_alarm_snooze_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alarm_snooze_controller: self-checking bench for the alarm controller
// Streams ticks, presses and mode writes into the block and predicts every
// result beat with a cycle-free model of the alarm. Each phase writes all
// registers while the block is idle, then runs alarm episodes; most phases add
// random gaps, stalls or both on the two channels. Result beats are compared field by field.
// ----------------------------------------------------------------------------
module tb_alarm_snooze_controller;
  import asc_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 2000;  // cycles with no beat at all
  localparam int unsigned HOLD_OFF_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned PHASE_ITEMS     = 240;
  localparam int unsigned NUM_PHASES      = 7;

  // Local copy of the register file, kept at register widths
  typedef struct {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
    logic [6:0] snz_min;
    logic [3:0] snz_max;
    logic [1:0] signals;
    logic [7:0] level;
    logic       inhibit;
  } alarm_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  asc_item_if   item_ch();
  asc_result_if result_ch();

  alarm_snooze_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always #2 clk = ~clk;

  // Predicted alarm state
  alarm_cfg_t  cur_cfg;
  logic [1:0]  cur_mode;
  logic        ringing, snoozing, armed;
  logic [3:0]  snz_left;
  logic [31:0] snz_t0, ring_t0;

  // Stimulus and scoreboard storage
  item_t       alarm_events_todo[$];
  result_t     alarm_outputs_due[$];
  item_t       offered;
  result_t     outcome;
  result_t     due;
  logic [31:0] wall_ms;
  int unsigned stim_count;
  int unsigned mismatches = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        pressure_on = 1'b0;
  int unsigned hold_count;
  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // Alarm prediction
  // --------------------------------------------------------------------------

  // Stop the alarm: clear ringing and snooze, fade out, switch used outputs off
  task automatic halt_alarm(inout result_t r);
    ringing  = 1'b0;
    snoozing = 1'b0;
    snz_left = '0;
    r.ambient_cmd    = AMB_FADE_OUT;
    r.ambient_target = '0;
    if (cur_cfg.signals[0]) r.lamp_cmd = LAMP_OFF;
    if (cur_cfg.signals[1]) r.buzzer_cmd = BUZZ_OFF;
    r.stopped = 1'b1;
  endtask

  task automatic predict_alarm_output(input item_t it, output result_t r);
    logic [31:0] period;
    logic [31:0] span;
    logic        guarded, day_ok, hit;
    r = '0;
    period = 32'(cur_cfg.snz_min) * MS_PER_MINUTE;
    case (it.kind)
      KIND_TICK: begin
        if (ringing) begin
          // Active: only wake and timeout checks, never a fresh trigger
          if (snoozing) begin
            span = it.now_ms - snz_t0;
            if (span >= period) begin
              snoozing = 1'b0;
              if (cur_cfg.signals[0]) r.lamp_cmd = LAMP_ON;
              if (cur_cfg.signals[1])
                r.buzzer_cmd = (snz_left == 0) ? BUZZ_LAST : BUZZ_REGULAR;
              ring_t0 = it.now_ms;
            end
          end else begin
            span = it.now_ms - ring_t0;
            if (span >= RING_TIMEOUT_MS) halt_alarm(r);
          end
        end else begin
          span    = it.now_ms - ring_t0;
          guarded = armed && (span < GUARD_MS);
          day_ok  = (it.weekday != 3'd7) && cur_cfg.days[it.weekday];
          hit     = (it.hour_now == cur_cfg.hour) && (it.minute_now == cur_cfg.minute) &&
                    (cur_mode != MODE_OFF);
          if (!guarded && day_ok && hit) begin
            ring_t0 = it.now_ms;
            armed   = 1'b1;
            if (cur_mode == MODE_SINGLE) begin
              cur_mode = MODE_OFF;
              r.persist_request = 1'b1;
            end
            if (cur_mode == MODE_SKIP) begin
              // Skip consumes this trigger silently
              cur_mode = MODE_REPEAT;
              r.persist_request = 1'b1;
            end else if (!cur_cfg.inhibit) begin
              snz_left = cur_cfg.snz_max;
              snoozing = 1'b0;
              ringing  = 1'b1;
              if (cur_cfg.signals[1])
                r.buzzer_cmd = (snz_left == 0) ? BUZZ_LAST : BUZZ_REGULAR;
              r.ambient_cmd    = AMB_FADE_IN;
              r.ambient_target = cur_cfg.level;
              if (cur_cfg.signals[0]) r.lamp_cmd = LAMP_ON;
              r.activated = 1'b1;
            end
          end
        end
      end
      KIND_SNOOZE: begin
        if (ringing && !snoozing && snz_left != 0) begin
          snoozing = 1'b1;
          snz_left = snz_left - 4'd1;
          snz_t0   = it.now_ms;
          if (cur_cfg.signals[0]) r.lamp_cmd = LAMP_OFF;
          if (cur_cfg.signals[1]) r.buzzer_cmd = BUZZ_OFF;
        end
      end
      KIND_STOP: begin
        if (ringing) halt_alarm(r);
      end
      KIND_MODE: begin
        cur_mode   = it.mode_value;
        r.write_ok = 1'b1;
      end
    endcase
    r.mode_now     = cur_mode;
    r.is_active    = ringing;
    r.is_snoozing  = ringing && snoozing;
    r.snoozes_left = ringing ? snz_left : 4'd0;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer queued beats, predict each one on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_alarm_output(offered, outcome);
        alarm_outputs_due.push_back(outcome);
      end
      // Advance only when the slot is free; otherwise hold the beat steady
      if (!item_ch.valid || item_ch.ready) begin
        if (alarm_events_todo.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = alarm_events_todo.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.data  <= offered;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver hold-off: count cycles since the pressure phase began
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !pressure_on) begin
      hold_count <= 0;
    end else if (hold_count != HOLD_OFF_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted beat with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (alarm_outputs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 50)
            $display("%0t: result beat with nothing expected, expected none, got %p",
                     $time, result_ch.data);
        end else begin
          due = alarm_outputs_due.pop_front();
          cmp_field("lamp_cmd", 32'(due.lamp_cmd), 32'(result_ch.data.lamp_cmd));
          cmp_field("buzzer_cmd", 32'(due.buzzer_cmd), 32'(result_ch.data.buzzer_cmd));
          cmp_field("ambient_cmd", 32'(due.ambient_cmd), 32'(result_ch.data.ambient_cmd));
          cmp_field("ambient_target", 32'(due.ambient_target),
                    32'(result_ch.data.ambient_target));
          cmp_field("activated", 32'(due.activated), 32'(result_ch.data.activated));
          cmp_field("stopped", 32'(due.stopped), 32'(result_ch.data.stopped));
          cmp_field("persist_request", 32'(due.persist_request),
                    32'(result_ch.data.persist_request));
          cmp_field("mode_now", 32'(due.mode_now), 32'(result_ch.data.mode_now));
          cmp_field("is_active", 32'(due.is_active), 32'(result_ch.data.is_active));
          cmp_field("is_snoozing", 32'(due.is_snoozing), 32'(result_ch.data.is_snoozing));
          cmp_field("snoozes_left", 32'(due.snoozes_left),
                    32'(result_ch.data.snoozes_left));
          cmp_field("write_ok", 32'(due.write_ok), 32'(result_ch.data.write_ok));
        end
      end
      // Drop ready for the whole hold-off, otherwise stall at random
      result_ch.ready <= !(pressure_on && hold_count != HOLD_OFF_CYCLES) &&
                         ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Write every register and mirror it in the predictor copy
  task automatic apply_settings(input alarm_cfg_t s);
    write_reg(REG_ALARM_HOUR,     CFG_DATA_W'(s.hour));
    write_reg(REG_ALARM_MINUTE,   CFG_DATA_W'(s.minute));
    write_reg(REG_DAY_MASK,       CFG_DATA_W'(s.days));
    write_reg(REG_SNOOZE_MINUTES, CFG_DATA_W'(s.snz_min));
    write_reg(REG_SNOOZE_LIMIT,   CFG_DATA_W'(s.snz_max));
    write_reg(REG_SIGNAL_FLAGS,   CFG_DATA_W'(s.signals));
    write_reg(REG_AMBIENT_LEVEL,  s.level);
    write_reg(REG_INHIBIT,        CFG_DATA_W'(s.inhibit));
    cur_cfg = s;
  endtask

  function automatic alarm_cfg_t roll_settings(input logic inh);
    alarm_cfg_t s;
    s.hour    = 5'($urandom_range(23));
    s.minute  = 6'($urandom_range(59));
    s.days    = 7'($urandom_range(1, 127));
    s.snz_min = 7'($urandom_range(5));
    s.snz_max = 4'($urandom_range(15));
    s.signals = 2'($urandom_range(3));
    s.level   = 8'($urandom_range(255));
    s.inhibit = inh;
    return s;
  endfunction

  task automatic push_event(input logic [1:0] kind, input logic [31:0] now,
                            input int unsigned wd, input int unsigned hr,
                            input int unsigned mn, input logic [1:0] mv);
    item_t it;
    it.kind       = kind;
    it.now_ms     = now;
    it.weekday    = 3'(wd);
    it.hour_now   = 5'(hr);
    it.minute_now = 6'(mn);
    it.mode_value = mv;
    alarm_events_todo.push_back(it);
    stim_count++;
  endtask

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(9) == 0) return MODE_OFF;
    return 2'($urandom_range(1, 3));
  endfunction

  // Fully random beat; it does not count toward the phase total
  task automatic push_noise();
    push_event(2'($urandom_range(3)), $urandom, $urandom_range(7), $urandom_range(23),
               $urandom_range(59), 2'($urandom_range(3)));
    stim_count--;
  endtask

  task automatic push_press(input logic [1:0] kind);
    push_event(kind, wall_ms, $urandom_range(7), $urandom_range(23), $urandom_range(59),
               2'($urandom_range(3)));
  endtask

  task automatic push_plain_tick();
    push_event(KIND_TICK, wall_ms, $urandom_range(7), $urandom_range(23), $urandom_range(59),
               2'($urandom_range(3)));
  endtask

  // Tick on an allowed weekday at the alarm hour and minute
  task automatic push_alarm_tick();
    int unsigned wd;
    wd = $urandom_range(6);
    if (cur_cfg.days != 0)
      while (!cur_cfg.days[wd]) wd = $urandom_range(6);
    push_event(KIND_TICK, wall_ms, wd, 32'(cur_cfg.hour), 32'(cur_cfg.minute),
               2'($urandom_range(3)));
  endtask

  // One alarm episode: optional mode write, a trigger, then presses and ticks
  // placed around the snooze period and the ring timeout
  task automatic add_episode();
    logic [31:0] period;
    int unsigned steps;
    period = 32'(cur_cfg.snz_min) * MS_PER_MINUTE;
    if ($urandom_range(15) == 0) wall_ms = $urandom;
    if ($urandom_range(5) == 0) push_noise();
    if ($urandom_range(2) != 0) push_press(KIND_MODE);
    if ($urandom_range(2) != 0)
      push_event(KIND_MODE, wall_ms, 0, 0, 0, pick_mode());
    wall_ms += $urandom_range(1, 5000);
    push_alarm_tick();
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      case ($urandom_range(9))
        0, 1: begin
          wall_ms += $urandom_range(100, 20000);
          push_press(KIND_SNOOZE);
        end
        2: begin
          wall_ms += period + $urandom_range(0, 3000);
          push_plain_tick();
        end
        3: begin
          wall_ms += (period != 0) ? period - 1 : 32'd0;
          push_plain_tick();
        end
        4: begin
          wall_ms += $urandom_range(1000, 100000);
          push_plain_tick();
        end
        5: begin
          wall_ms += RING_TIMEOUT_MS - 1 + $urandom_range(0, 2);
          push_plain_tick();
        end
        6: push_press(KIND_STOP);
        7: push_event(KIND_MODE, wall_ms, 0, 0, 0, pick_mode());
        8: begin
          wall_ms += $urandom_range(0, 70000);
          push_alarm_tick();
        end
        default: push_noise();
      endcase
    end
    if ($urandom_range(3) != 0) push_press(KIND_STOP);
    // Mostly clear the 62 s guard before the next trigger, sometimes not
    if ($urandom_range(3) == 0) wall_ms += $urandom_range(0, 61999);
    else wall_ms += 62000 + $urandom_range(0, 200000);
  endtask

  // Wait until every queued beat has gone in and every prediction came back
  task automatic drain();
    while (alarm_events_todo.size() != 0 || item_ch.valid || alarm_outputs_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    alarm_cfg_t s;
    // Drive every input to a known value before the first edge
    rst             = 1'b1;
    cfg_wen         = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
    // Predictor starts from the reset state
    cur_cfg  = '{default: '0};
    cur_mode = MODE_OFF;
    ringing  = 1'b0;
    snoozing = 1'b0;
    armed    = 1'b0;
    snz_left = '0;
    snz_t0   = '0;
    ring_t0  = '0;
    wall_ms  = $urandom;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: weekdays Monday to Friday at 7:30, one snooze of a minute
    s = '{hour: 5'd7, minute: 6'd30, days: 7'h3E, snz_min: 7'd1, snz_max: 4'd1,
          signals: 2'd3, level: 8'd200, inhibit: 1'b0};
    apply_settings(s);
    @(negedge clk);
    push_event(KIND_STOP,   32'd0,      0, 0, 0,  MODE_OFF);    // presses while idle
    push_event(KIND_SNOOZE, 32'd0,      0, 0, 0,  MODE_OFF);
    push_event(KIND_TICK,   32'd500,    1, 7, 30, MODE_OFF);    // mode off, no trigger
    push_event(KIND_MODE,   32'd550,    0, 0, 0,  MODE_SINGLE);
    push_event(KIND_TICK,   32'd600,    0, 7, 30, MODE_OFF);    // Sunday masked out
    push_event(KIND_TICK,   32'd700,    7, 7, 30, MODE_OFF);    // weekday seven
    push_event(KIND_TICK,   32'd800,    1, 7, 29, MODE_OFF);    // wrong minute
    push_event(KIND_TICK,   32'd1000,   1, 7, 30, MODE_OFF);    // guard not armed yet
    push_event(KIND_SNOOZE, 32'd2000,   0, 0, 0,  MODE_OFF);
    push_event(KIND_SNOOZE, 32'd3000,   0, 0, 0,  MODE_OFF);    // already snoozing
    push_event(KIND_TICK,   32'd61999,  1, 7, 30, MODE_OFF);    // one ms short of wake
    push_event(KIND_TICK,   32'd62000,  1, 7, 30, MODE_OFF);    // wake, last ring
    push_event(KIND_SNOOZE, 32'd63000,  0, 0, 0,  MODE_OFF);    // no snoozes left
    push_event(KIND_MODE,   32'd64000,  0, 0, 0,  MODE_SKIP);   // write while ringing
    push_event(KIND_TICK,   32'd661999, 1, 0, 0,  MODE_OFF);    // one ms short of timeout
    push_event(KIND_TICK,   32'd662000, 1, 0, 0,  MODE_OFF);    // timeout stop
    push_event(KIND_TICK,   32'd663000, 1, 7, 30, MODE_OFF);    // skip becomes repeat
    push_event(KIND_TICK,   32'd724999, 1, 7, 30, MODE_OFF);    // inside guard
    push_event(KIND_TICK,   32'd725000, 1, 7, 30, MODE_OFF);    // guard just over
    push_event(KIND_STOP,   32'd726000, 0, 0, 0,  MODE_OFF);
    push_event(KIND_STOP,   32'd727000, 0, 0, 0,  MODE_OFF);    // stop while idle
    push_event(KIND_TICK,   32'hFFFF_FF00, 5, 7, 30, MODE_OFF); // ring across the wrap
    push_event(KIND_TICK,   32'd599743, 5, 0, 0,  MODE_OFF);
    push_event(KIND_TICK,   32'd599744, 5, 0, 0,  MODE_OFF);    // timeout after wrap
    push_event(KIND_MODE,   32'd600000, 0, 0, 0,  MODE_OFF);
    push_event(KIND_MODE,   32'd600001, 0, 0, 0,  MODE_REPEAT);
    drain();

    // Random phases: cycle the idling patterns, one phase holds the receiver off
    for (int unsigned phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: s = '{hour: 5'd23, minute: 6'd59, days: 7'h7F, snz_min: 7'd99, snz_max: 4'd15,
                 signals: 2'd3, level: 8'd255, inhibit: 1'b0};
        2: s = '{hour: 5'd0, minute: 6'd0, days: 7'h01, snz_min: 7'd0, snz_max: 4'd0,
                 signals: 2'd0, level: 8'd0, inhibit: 1'b0};
        4: s = roll_settings(1'b1);
        7: s = '{hour: 5'd12, minute: 6'd34, days: 7'h7F, snz_min: 7'd0, snz_max: 4'd9,
                 signals: 2'd2, level: 8'd128, inhibit: 1'b0};
        default: s = roll_settings($urandom_range(3) == 0);
      endcase
      apply_settings(s);
      @(negedge clk);
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
        default: begin send_gap_pct = 8; recv_stall_pct = 8; end
      endcase
      if (phase == 1) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      // Keep offering beats while the receiver holds off so the block backs up
      pressure_on = (phase == 6);
      stim_count  = 0;
      while (stim_count < PHASE_ITEMS) add_episode();
      drain();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
